// ===== hdl/psuf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psuf_pkg
// Shared types and constants of the PCM sample byte framer.
// ----------------------------------------------------------------------------
package psuf_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 15;
  localparam int unsigned LenW     = 16;
  localparam int unsigned SampleLo = 16;

  localparam logic [ByteW-1:0]  SYNC_FIRST          = 8'hA5;
  localparam logic [ByteW-1:0]  SYNC_SECOND         = 8'h5A;
  localparam logic [CountW-1:0] FRAME_SAMPLES_RESET = 15'd160;

  // Byte slots of one command, in stream order
  localparam int unsigned NSlots        = 8;
  localparam int unsigned SLOT_CSUM_PRE  = 0;
  localparam int unsigned SLOT_SYNC0     = 1;
  localparam int unsigned SLOT_SYNC1     = 2;
  localparam int unsigned SLOT_LEN_LO    = 3;
  localparam int unsigned SLOT_LEN_HI    = 4;
  localparam int unsigned SLOT_SMP_LO    = 5;
  localparam int unsigned SLOT_SMP_HI    = 6;
  localparam int unsigned SLOT_CSUM_POST = 7;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef logic [CountW-1:0] frame_cnt_t;
  typedef logic [ByteW-1:0]  byte_t;

  typedef struct packed {
    logic [NSlots-1:0]             mask;
    logic [NSlots-1:0][ByteW-1:0]  bytes;
  } psuf_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } psuf_fifo_stat_t;

endpackage

// ===== hdl/psuf_word_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psuf_word_if
// Valid/ready channel carrying raw I2S receive words.
// ----------------------------------------------------------------------------
interface psuf_word_if;
  import psuf_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] i2s_word;

  modport source (output valid, output i2s_word, input ready);
  modport sink   (input valid, input i2s_word, output ready);

endinterface

// ===== hdl/psuf_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psuf_byte_if
// Valid/ready channel carrying framed stream bytes.
// ----------------------------------------------------------------------------
interface psuf_byte_if;
  import psuf_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             frame_end;
  logic             run_last;

  modport source (output valid, output out_byte, output frame_end, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input run_last,
                  output ready);

endinterface

// ===== hdl/psuf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psuf_front
// Accepts I2S words, keeps the frame state and turns each word into a
// command listing the stream bytes it causes.
// ----------------------------------------------------------------------------
module psuf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  psuf_pkg::frame_cnt_t cfg_wdata_i,
  psuf_word_if.sink           word_i,
  input  logic                full_i,
  output logic                push_o,
  output psuf_pkg::psuf_cmd_t cmd_o
);
  import psuf_pkg::*;

  frame_cnt_t frame_samples_q;
  logic       phase_q, phase_d;
  frame_cnt_t sif_q, sif_d;
  byte_t      xor_q, xor_d;
  logic       pending_q, pending_d;

  logic       accept;
  logic       keep;
  frame_cnt_t eff;
  frame_cnt_t sif_inc;
  logic       header_now;
  logic       frame_done;
  logic [LenW-1:0] len;
  byte_t      smp_lo, smp_hi;
  byte_t      xor_base, xor_new;

  assign word_i.ready = !full_i;
  assign accept       = word_i.valid && word_i.ready;
  assign keep         = !phase_q;

  always_comb begin
    eff        = (frame_samples_q == '0) ? frame_cnt_t'(1) : frame_samples_q;
    header_now = (sif_q == '0);
    sif_inc    = sif_q + frame_cnt_t'(1);
    frame_done = (sif_inc >= eff);
    len        = {eff, 1'b0};
    smp_lo     = word_i.i2s_word[SampleLo +: ByteW];
    smp_hi     = word_i.i2s_word[SampleLo + ByteW +: ByteW];
    xor_base   = pending_q ? '0 : xor_q;
    xor_new    = xor_base ^ smp_lo ^ smp_hi;

    cmd_o.mask                   = '0;
    cmd_o.mask[SLOT_CSUM_PRE]    = pending_q;
    cmd_o.mask[SLOT_SYNC0]       = keep && header_now;
    cmd_o.mask[SLOT_SYNC1]       = keep && header_now;
    cmd_o.mask[SLOT_LEN_LO]      = keep && header_now;
    cmd_o.mask[SLOT_LEN_HI]      = keep && header_now;
    cmd_o.mask[SLOT_SMP_LO]      = keep;
    cmd_o.mask[SLOT_SMP_HI]      = keep;
    cmd_o.mask[SLOT_CSUM_POST]   = keep && frame_done && !header_now;

    cmd_o.bytes                  = '0;
    cmd_o.bytes[SLOT_CSUM_PRE]   = xor_q;
    cmd_o.bytes[SLOT_SYNC0]      = SYNC_FIRST;
    cmd_o.bytes[SLOT_SYNC1]      = SYNC_SECOND;
    cmd_o.bytes[SLOT_LEN_LO]     = len[ByteW-1:0];
    cmd_o.bytes[SLOT_LEN_HI]     = len[LenW-1:ByteW];
    cmd_o.bytes[SLOT_SMP_LO]     = smp_lo;
    cmd_o.bytes[SLOT_SMP_HI]     = smp_hi;
    cmd_o.bytes[SLOT_CSUM_POST]  = xor_new;

    // drop words that cause no byte at all
    push_o = accept && (cmd_o.mask != '0);

    phase_d   = phase_q;
    sif_d     = sif_q;
    xor_d     = xor_q;
    pending_d = pending_q;
    if (accept) begin
      phase_d   = !phase_q;
      xor_d     = xor_base;
      pending_d = 1'b0;
      if (keep) begin
        sif_d = frame_done ? '0 : sif_inc;
        xor_d = (frame_done && !header_now) ? '0 : xor_new;
        // one-sample frame: hold the checksum for the next transfer
        pending_d = frame_done && header_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_samples_q <= FRAME_SAMPLES_RESET;
      phase_q         <= 1'b0;
      sif_q           <= '0;
      xor_q           <= '0;
      pending_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_samples_q <= cfg_wdata_i;
      end
      phase_q   <= phase_d;
      sif_q     <= sif_d;
      xor_q     <= xor_d;
      pending_q <= pending_d;
    end
  end

endmodule

// ===== hdl/psuf_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psuf_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module psuf_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  psuf_pkg::psuf_cmd_t      cmd_i,
  input  logic                     pop_i,
  output psuf_pkg::psuf_cmd_t      cmd_o,
  output psuf_pkg::psuf_fifo_stat_t stat_o
);
  import psuf_pkg::*;

  psuf_cmd_t         mem_q [FifoDepth];
  logic [FifoAw:0]   wptr_q, wptr_d;
  logic [FifoAw:0]   rptr_q, rptr_d;

  always_comb begin
    stat_o.empty = (wptr_q == rptr_q);
    stat_o.full  = (wptr_q[FifoAw] != rptr_q[FifoAw]) &&
                   (wptr_q[FifoAw-1:0] == rptr_q[FifoAw-1:0]);
    cmd_o        = mem_q[rptr_q[FifoAw-1:0]];
    wptr_d       = wptr_q + (FifoAw+1)'(push_i);
    rptr_d       = rptr_q + (FifoAw+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q[FifoAw-1:0]] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

endmodule

// ===== hdl/psuf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psuf_back
// Walks the byte slots of each command and sends one byte per cycle, while
// the byte sink is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module psuf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_empty_i,
  input  psuf_pkg::psuf_cmd_t cmd_i,
  output logic                pop_o,
  output logic                busy_o,
  psuf_byte_if.source         byte_o
);
  import psuf_pkg::*;

  logic [NSlots-1:0]            mask_q, mask_d;
  logic [NSlots-1:0][ByteW-1:0] bytes_q;
  logic                         out_valid_q, out_valid_d;
  byte_t                        out_byte_q, out_byte_d;
  logic                         frame_end_q, frame_end_d;
  logic                         run_last_q, run_last_d;

  logic              advance;
  logic              emit;
  logic [NSlots-1:0] sel;
  logic [NSlots-1:0] rem;
  byte_t             sel_byte;

  assign busy_o = (mask_q != '0);

  always_comb begin
    advance  = !out_valid_q || byte_o.ready;
    emit     = advance && (mask_q != '0);
    sel      = mask_q & (~mask_q + NSlots'(1));
    rem      = mask_q & ~sel;
    sel_byte = '0;
    for (int k = 0; k < NSlots; k++) begin
      sel_byte = sel_byte | (bytes_q[k] & {ByteW{sel[k]}});
    end

    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    frame_end_d = frame_end_q;
    run_last_d  = run_last_q;
    if (advance) begin
      out_valid_d = emit;
      out_byte_d  = sel_byte;
      frame_end_d = sel[SLOT_CSUM_PRE] || sel[SLOT_CSUM_POST];
      run_last_d  = (rem == '0);
    end

    mask_d = emit ? rem : mask_q;
    // refill as soon as the current command has gone
    pop_o  = !fifo_empty_i && (mask_d == '0);
    if (pop_o) begin
      mask_d = cmd_i.mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bytes_q <= cmd_i.bytes;
    end
    out_byte_q  <= out_byte_d;
    frame_end_q <= frame_end_d;
    run_last_q  <= run_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign byte_o.valid     = out_valid_q;
  assign byte_o.out_byte  = out_byte_q;
  assign byte_o.frame_end = frame_end_q;
  assign byte_o.run_last  = run_last_q;

endmodule

// ===== hdl/pcm_sample_uart_framer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_sample_uart_framer_top
// Frames left-channel PCM samples from I2S words into a checked byte stream.
// ----------------------------------------------------------------------------
// Every other input word, starting with the first after reset, is kept and its
// upper 16 bits sent as a sample, low byte first; a frame opens with A5 5A and
// the payload length and closes with the XOR of its payload bytes. An input
// word is taken whenever the four-entry command queue has room; the output
// side sends one byte per cycle from its output register while the byte sink
// is ready, so a kept word causes two bytes, four more when it opens a frame
// and one more when it closes one. A dropped word causes none, or one when it
// carries the held checksum of a one-sample frame. With the output side idle,
// a taken word passes the command queue, the slot mask register and the
// output register before its first byte is valid. Inside a frame a
// left/right pair yields two bytes, so the input runs at one word per cycle
// while the byte sink keeps up. The four header bytes and the checksum of
// each frame add five more bytes, and the input stalls while the queue is
// full. The run_last flag marks the last byte caused by an input word.
// ----------------------------------------------------------------------------
module pcm_sample_uart_framer_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  psuf_pkg::frame_cnt_t cfg_wdata_i,
  psuf_word_if.sink            word_i,
  psuf_byte_if.source          byte_o
);
  import psuf_pkg::*;

  logic            push;
  logic            pop;
  logic            back_busy;
  psuf_cmd_t       cmd_in;
  psuf_cmd_t       cmd_out;
  psuf_fifo_stat_t fifo_st;

  psuf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (word_i),
    .full_i      (fifo_st.full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  psuf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .stat_o (fifo_st)
  );

  psuf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_st.empty),
    .cmd_i        (cmd_out),
    .pop_o        (pop),
    .busy_o       (back_busy),
    .byte_o       (byte_o)
  );

  // a checksum is always the last byte of its input word
  a_csum_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_o.valid && byte_o.frame_end |-> byte_o.run_last)
    else $error("checksum byte not flagged as last of its word");

  // the back part never sits idle while the queue holds a command
  a_back_refills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_st.empty && !back_busy |=> back_busy)
    else $error("queued command not picked up");

  // nothing is popped from an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_st.empty)
    else $error("pop from empty command queue");

endmodule
